### rtl/ncp_pkg.sv
`default_nettype none
package ncp_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int PROD_W  = 2 * COMPONENT_WIDTH;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = 31;                 // magnitudes kept below 2^31
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ACC_W   = 100;                // signed remainder / t*S width
    localparam int Q_W     = 15;                 // quotient 0..16384
    localparam int OUT_W   = 16;
    localparam int SH_W    = $clog2(PROD_W + 1);
    localparam int FRAC_SH = 30;                 // (2^15)^2 scale of mag^2

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] ax;
        logic signed [COMPONENT_WIDTH-1:0] ay;
        logic signed [COMPONENT_WIDTH-1:0] az;
        logic signed [COMPONENT_WIDTH-1:0] bx;
        logic signed [COMPONENT_WIDTH-1:0] by;
        logic signed [COMPONENT_WIDTH-1:0] bz;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] nx;
        logic signed [OUT_W-1:0] ny;
        logic signed [OUT_W-1:0] nz;
        logic                    degenerate;
    } t_out;

    typedef struct packed {
        logic signed [PROD_W-1:0] p0;
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p2;
        logic signed [PROD_W-1:0] p3;
        logic signed [PROD_W-1:0] p4;
        logic signed [PROD_W-1:0] p5;
    } t_prod;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  degen;
    } t_mag;

    typedef struct packed {
        logic [2:0][SQ_W-1:0] sq;
        logic [2:0]           neg;
        logic                 degen;
    } t_sq;

    typedef struct packed {
        logic [2:0][ACC_W-1:0] rem;
        logic [2:0][ACC_W-1:0] ts;
        logic [SUM_W-1:0]      s;
        logic [2:0][Q_W-1:0]   q;
        logic [2:0]            neg;
        logic                  degen;
    } t_root;

endpackage
`default_nettype wire

### rtl/ncp_mul.sv
`default_nettype none
module ncp_mul (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire ncp_pkg::t_in  i_d,
    output ncp_pkg::t_prod     o_d
);
    import ncp_pkg::*;

    t_prod r_d;
    t_prod n_d;

    always_comb begin
        n_d.p0 = i_d.ay * i_d.bz;
        n_d.p1 = i_d.az * i_d.by;
        n_d.p2 = i_d.az * i_d.bx;
        n_d.p3 = i_d.ax * i_d.bz;
        n_d.p4 = i_d.ax * i_d.by;
        n_d.p5 = i_d.ay * i_d.bx;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

### rtl/ncp_prep.sv
`default_nettype none
module ncp_prep (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire ncp_pkg::t_prod i_d,
    output ncp_pkg::t_mag       o_d
);
    import ncp_pkg::*;

    t_mag                       r_d;
    t_mag                       n_d;
    logic signed [CROSS_W-1:0]  c [3];
    logic [PROD_W-1:0]          m [3];
    logic [PROD_W-1:0]          m_or;
    logic [SH_W-1:0]            sh;

    always_comb begin
        c[0] = CROSS_W'(i_d.p0) - CROSS_W'(i_d.p1);
        c[1] = CROSS_W'(i_d.p2) - CROSS_W'(i_d.p3);
        c[2] = CROSS_W'(i_d.p4) - CROSS_W'(i_d.p5);
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i][CROSS_W-1] ? PROD_W'(-c[i]) : PROD_W'(c[i]);
            n_d.neg[i] = c[i][CROSS_W-1];
        end
        m_or = m[0] | m[1] | m[2];
        // common right shift so the largest magnitude drops below 2^31
        sh = '0;
        for (int i = MAG_W; i < PROD_W; i++) begin
            if (m_or[i]) begin
                sh = SH_W'(i - MAG_W + 1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            n_d.mag[i] = MAG_W'(m[i] >> sh);
        end
        n_d.degen = (m_or == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

### rtl/ncp_sq.sv
`default_nettype none
module ncp_sq (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire ncp_pkg::t_mag i_d,
    output ncp_pkg::t_sq       o_d
);
    import ncp_pkg::*;

    t_sq r_d;
    t_sq n_d;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_d.sq[i] = SQ_W'(i_d.mag[i]) * SQ_W'(i_d.mag[i]);
        end
        n_d.neg   = i_d.neg;
        n_d.degen = i_d.degen;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

### rtl/ncp_step.sv
`default_nettype none
// One quotient bit for all three lanes. q is the largest value with
// (2q-1)^2 * S <= mag^2 * 2^30; rem holds mag^2*2^30 - (2q-1)^2*S and
// ts holds (2q-1)*S, both updated by shifts and adds only.
module ncp_step #(
    parameter int BIT = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire ncp_pkg::t_root i_d,
    output ncp_pkg::t_root      o_d
);
    import ncp_pkg::*;

    t_root                   r_d;
    t_root                   n_d;
    logic signed [ACC_W-1:0] delta [3];
    logic signed [ACC_W-1:0] trial [3];
    logic [ACC_W-1:0]        s_ext;

    always_comb begin
        n_d   = i_d;
        s_ext = ACC_W'(i_d.s);
        for (int i = 0; i < 3; i++) begin
            delta[i] = $signed(i_d.ts[i] << (BIT + 2)) + $signed(s_ext << (2 * BIT + 2));
            trial[i] = $signed(i_d.rem[i]) - delta[i];
            if (!trial[i][ACC_W-1]) begin
                n_d.rem[i]    = trial[i];
                n_d.ts[i]     = i_d.ts[i] + (s_ext << (BIT + 1));
                n_d.q[i][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

### rtl/normalized_cross_product.sv
// Throughput: one word per cycle while i_stall is low; each of the 20 stages holds a word and
// moves on whenever the stage ahead is empty or moving.
// The quotient is built by 15 chained one-bit stages per component.
// Reset clears the stage valid bits only; data registers are not reset.
`default_nettype none
module normalized_cross_product (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire ncp_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output ncp_pkg::t_out      o_data
);
    import ncp_pkg::*;

    localparam int NST    = 5 + Q_W;   // mul, prep, sq, sum, steps, out
    localparam int ST_SUM = 3;

    logic [NST-1:0] r_valid;
    logic [NST-1:0] en;
    logic [NST-1:0] valid_in;

    t_prod s_prod;
    t_mag  s_mag;
    t_sq   s_sq;
    t_root r_sum;
    t_root n_sum;
    t_root s_root [Q_W+1];
    t_out  r_out;
    t_out  n_out;

    always_comb begin
        en[NST-1] = !r_valid[NST-1] || !i_stall;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_valid[NST-1];
    assign o_data  = r_out;

    // valid bit entering each stage
    assign valid_in = {r_valid[NST-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_valid[k] <= valid_in[k];
                end
            end
        end
    end

    ncp_mul u_mul (.i_clk(i_clk), .i_en(en[0]), .i_d(i_data), .o_d(s_prod));
    ncp_prep u_prep (.i_clk(i_clk), .i_en(en[1]), .i_d(s_prod), .o_d(s_mag));
    ncp_sq u_sq (.i_clk(i_clk), .i_en(en[2]), .i_d(s_mag), .o_d(s_sq));

    // sum of squares, start values for q = 0 (t = -1)
    always_comb begin
        n_sum.s = SUM_W'(s_sq.sq[0]) + SUM_W'(s_sq.sq[1]) + SUM_W'(s_sq.sq[2]);
        for (int i = 0; i < 3; i++) begin
            n_sum.rem[i] = (ACC_W'(s_sq.sq[i]) << FRAC_SH) - ACC_W'(n_sum.s);
            n_sum.ts[i]  = -ACC_W'(n_sum.s);
            n_sum.q[i]   = '0;
        end
        n_sum.neg   = s_sq.neg;
        n_sum.degen = s_sq.degen;
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_SUM]) begin
            r_sum <= n_sum;
        end
    end

    assign s_root[0] = r_sum;

    for (genvar g = 0; g < Q_W; g++) begin : g_step
        ncp_step #(.BIT(Q_W - 1 - g)) u_step (
            .i_clk (i_clk),
            .i_en  (en[ST_SUM + 1 + g]),
            .i_d   (s_root[g]),
            .o_d   (s_root[g+1])
        );
    end

    always_comb begin
        logic [OUT_W-1:0] v [3];
        for (int i = 0; i < 3; i++) begin
            v[i] = s_root[Q_W].neg[i] ? -OUT_W'(s_root[Q_W].q[i])
                                      : OUT_W'(s_root[Q_W].q[i]);
            if (s_root[Q_W].degen) begin
                v[i] = '0;
            end
        end
        n_out.nx         = v[0];
        n_out.ny         = v[1];
        n_out.nz         = v[2];
        n_out.degenerate = s_root[Q_W].degen;
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) begin
            r_out <= n_out;
        end
    end
endmodule
`default_nettype wire
